// ===== rtl/snt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snt_pkg: shared definitions for the scientific-notation tokenizer
// Parser phase codes, character constants, the parser state and result types,
// and the small character classifiers used by the parser.
// ----------------------------------------------------------------------------
package snt_pkg;

  // Parser phase codes.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_INT     = 3'd1;
  localparam logic [2:0] PH_FRAC    = 3'd2;
  localparam logic [2:0] PH_EXPMARK = 3'd3;
  localparam logic [2:0] PH_EXPSIGN = 3'd4;
  localparam logic [2:0] PH_EXPDIG  = 3'd5;

  // Item kinds.
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UPR_E = 8'h45;
  localparam logic [7:0] CH_LWR_E = 8'h65;
  localparam logic [7:0] CH_UPR_D = 8'h44;
  localparam logic [7:0] CH_LWR_D = 8'h64;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // State of the number being parsed.
  typedef struct packed {
    logic [2:0]  phase;
    logic        sign_neg;
    logic [31:0] mant;
    logic [15:0] frac_cnt;
    logic [15:0] exp_acc;
    logic        exp_neg;
    logic        int_seen;
  } snt_state_t;

  // One result item.
  typedef struct packed {
    logic               valid_res;
    logic               negative;
    logic [31:0]        mantissa;
    logic signed [15:0] exponent;
  } snt_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_marker(input logic [7:0] c);
    is_marker = (c == CH_UPR_E) || (c == CH_LWR_E) ||
                (c == CH_UPR_D) || (c == CH_LWR_D);
  endfunction

endpackage

// ===== rtl/snt_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snt_parser: number parser state and its update
// Holds the state of the number in progress, advances it by one item per
// step and forms the result item when a number ends.
// ----------------------------------------------------------------------------
module snt_parser
  import snt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       kind,
  input  logic [7:0] char_code,
  output logic       emit,
  output snt_res_t   res
);

  snt_state_t st_r;
  snt_state_t st_nxt;
  snt_state_t st_clr;
  snt_state_t st_start;
  snt_state_t st_take;
  logic       take_ok;
  logic       active;
  logic       c_digit;
  logic [7:0] c_diff;
  logic [3:0] dig;
  logic [31:0] mant_acc;
  logic [15:0] exp_acc_nxt;
  logic [15:0] exp_signed;

  // Digit value and the multiply-by-ten accumulations (shift and add).
  assign c_digit     = is_digit(char_code);
  assign c_diff      = char_code - CH_ZERO;
  assign dig         = c_diff[3:0];
  assign mant_acc    = (st_r.mant << 3) + (st_r.mant << 1) + {28'd0, dig};
  assign exp_acc_nxt = (st_r.exp_acc << 3) + (st_r.exp_acc << 1) + {12'd0, dig};

  assign active = (st_r.phase >= PH_INT) && (st_r.phase <= PH_EXPDIG);

  // Cleared state, and the state after a character starts a number.
  always_comb begin
    st_clr       = '0;
    st_clr.phase = PH_IDLE;
    st_start     = st_clr;
    if (char_code == CH_MINUS) begin
      st_start.sign_neg = 1'b1;
      st_start.phase    = PH_INT;
    end else if (char_code == CH_PLUS) begin
      st_start.phase = PH_INT;
    end else if (c_digit) begin
      st_start.mant     = {28'd0, dig};
      st_start.int_seen = 1'b1;
      st_start.phase    = PH_INT;
    end else if (char_code == CH_DOT) begin
      st_start.phase = PH_FRAC;
    end else if (is_marker(char_code)) begin
      st_start.phase = PH_EXPMARK;
    end
  end

  // State after a character continues the current number.
  always_comb begin
    st_take = st_r;
    take_ok = 1'b0;
    case (st_r.phase)
      PH_INT: begin
        if (c_digit) begin
          st_take.mant     = mant_acc;
          st_take.int_seen = 1'b1;
          take_ok          = 1'b1;
        end else if (char_code == CH_DOT) begin
          st_take.phase = PH_FRAC;
          take_ok       = 1'b1;
        end else if (is_marker(char_code)) begin
          st_take.phase = PH_EXPMARK;
          take_ok       = 1'b1;
        end
      end
      PH_FRAC: begin
        if (c_digit) begin
          st_take.mant     = mant_acc;
          st_take.frac_cnt = st_r.frac_cnt + 16'd1;
          take_ok          = 1'b1;
        end else if (is_marker(char_code)) begin
          st_take.phase = PH_EXPMARK;
          take_ok       = 1'b1;
        end
      end
      PH_EXPMARK, PH_EXPSIGN, PH_EXPDIG: begin
        // Only directly after the marker may an exponent sign appear.
        if ((st_r.phase == PH_EXPMARK) && (char_code == CH_MINUS)) begin
          st_take.exp_neg = 1'b1;
          st_take.phase   = PH_EXPSIGN;
          take_ok         = 1'b1;
        end else if ((st_r.phase == PH_EXPMARK) && (char_code == CH_PLUS)) begin
          st_take.phase = PH_EXPSIGN;
          take_ok       = 1'b1;
        end else if (c_digit) begin
          st_take.exp_acc = exp_acc_nxt;
          st_take.phase   = PH_EXPDIG;
          take_ok         = 1'b1;
        end
      end
      default: begin
        take_ok = 1'b0;
      end
    endcase
  end

  // Choose the next state; a character that does not fit ends the number
  // and is examined again as a possible start.
  always_comb begin
    st_nxt = st_r;
    emit   = 1'b0;
    if (step) begin
      if (kind == KIND_FLUSH) begin
        emit   = active;
        st_nxt = st_clr;
      end else if (!active) begin
        st_nxt = st_start;
      end else if (take_ok) begin
        st_nxt = st_take;
      end else begin
        emit   = 1'b1;
        st_nxt = st_start;
      end
    end
  end

  // Result item built from the state of the number that ends.
  assign exp_signed    = st_r.exp_neg ? (16'd0 - st_r.exp_acc) : st_r.exp_acc;
  assign res.valid_res = st_r.int_seen &&
                         (st_r.phase != PH_EXPMARK) && (st_r.phase != PH_EXPSIGN);
  assign res.negative  = st_r.sign_neg;
  assign res.mantissa  = st_r.mant;
  assign res.exponent  = exp_signed - st_r.frac_cnt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_clr;
    end else begin
      st_r <= st_nxt;
    end
  end

`ifndef SYNTHESIS
  // A flush always leaves the parser idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && (kind == KIND_FLUSH)) |=> (st_r.phase == PH_IDLE))
    else $error("parser not idle after flush");

  // A flush with no number in progress gives no result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && (kind == KIND_FLUSH) && (st_r.phase == PH_IDLE)) |-> !emit)
    else $error("result emitted for flush while idle");

  // Results come only from a processed item.
  assert property (@(posedge clk) disable iff (!rst_n) emit |-> step)
    else $error("result emitted without an item");

  // The phase never leaves the defined range.
  assert property (@(posedge clk) disable iff (!rst_n) st_r.phase <= PH_EXPDIG)
    else $error("parser phase out of range");
`endif

endmodule

// ===== rtl/snt_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snt_out_buf: two-entry result buffer
// Registers result items and holds them while the output channel stalls, so
// that the parser keeps running while one result waits.
// ----------------------------------------------------------------------------
module snt_out_buf
  import snt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  snt_res_t push_res,
  output logic     ready,
  output logic     out_valid,
  input  logic     out_stall,
  output snt_res_t out_res
);

  snt_res_t   mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;

  // There is room for one more item whenever the buffer is not full.
  assign ready     = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/sci_notation_number_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_notation_number_tokenizer: decimal scientific-notation tokenizer
// Parses ASCII numbers of the form [sign] digits [. digits] [E|e|D|d [sign]
// digits] into sign, 32-bit mantissa and 16-bit decimal exponent.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle without pause as long as the
// output side keeps up. An accepted item is held in an input register,
// goes through the parser update (a multiply by ten done as shift and add)
// and its result, if any, is written to a two-entry output buffer, which
// presents it at the output until it is taken. The input stalls only when
// the output buffer is full and the input register holds an item; one
// result may wait at the output while parsing goes on.
// ----------------------------------------------------------------------------
module sci_notation_number_tokenizer
  import snt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [7:0]         in_char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_valid_res,
  output logic               out_negative,
  output logic [31:0]        out_mantissa,
  output logic signed [15:0] out_exponent
);

  logic       in_vld_r;
  logic       in_kind_r;
  logic [7:0] in_char_r;
  logic       in_acc;
  logic       adv;
  logic       buf_ready;
  logic       emit;
  snt_res_t   res;
  snt_res_t   out_res;

  // The held item moves on when the buffer has room for its result.
  assign adv      = in_vld_r && buf_ready;
  assign in_stall = in_vld_r && !buf_ready;
  assign in_acc   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_kind_r <= in_kind;
      in_char_r <= in_char_code;
    end
  end

  // Parser.
  snt_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .kind      (in_kind_r),
    .char_code (in_char_r),
    .emit      (emit),
    .res       (res)
  );

  // Result buffer.
  snt_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_res  (res),
    .ready     (buf_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_valid_res = out_res.valid_res;
  assign out_negative  = out_res.negative;
  assign out_mantissa  = out_res.mantissa;
  assign out_exponent  = out_res.exponent;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the scientific-notation number tokenizer
// Drives character and end-of-text items into the tokenizer, predicts every
// parsed number with a local parser model, and checks each result field by
// field. Directed strings cover the number forms and malformed input, a long
// output hold-off follows, then a stream of random numbers, noise and flushes
// runs with random idling on both sides, and finally a stretch without idling.
// ----------------------------------------------------------------------------
module tb_top;
  import snt_pkg::*;

  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = KIND_CHAR;
  logic [7:0]         in_char_code = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_valid_res;
  logic               out_negative;
  logic [31:0]        out_mantissa;
  logic signed [15:0] out_exponent;

  // Parser state tracked by the testbench and the numbers still to come out.
  snt_state_t num_st;
  snt_res_t   pending_numbers[$];

  int  items_sent = 0;
  int  mismatch_cnt = 0;
  int  quiet_cycles = 0;
  bit  idle_enable = 1'b1;
  logic hold_req = 1'b0;
  logic hold_req_q = 1'b0;
  int  hold_left = 0;
  int  rx_burst = 0;

  sci_notation_number_tokenizer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_char_code  (in_char_code),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_negative  (out_negative),
    .out_mantissa  (out_mantissa),
    .out_exponent  (out_exponent)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser prediction
  // ---------------------------------------------------------------------------
  function automatic bit char_is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic bit char_is_marker(logic [7:0] c);
    return (c == CH_UPR_E) || (c == CH_LWR_E) || (c == CH_UPR_D) || (c == CH_LWR_D);
  endfunction

  function automatic void clear_number();
    num_st       = '0;
    num_st.phase = PH_IDLE;
  endfunction

  // A sign, digit, point or marker opens a number; anything else is dropped.
  function automatic void open_number(logic [7:0] c);
    clear_number();
    if (c == CH_MINUS) begin
      num_st.sign_neg = 1'b1;
      num_st.phase    = PH_INT;
    end else if (c == CH_PLUS) begin
      num_st.phase = PH_INT;
    end else if (char_is_digit(c)) begin
      num_st.mant     = 32'(c - CH_ZERO);
      num_st.int_seen = 1'b1;
      num_st.phase    = PH_INT;
    end else if (c == CH_DOT) begin
      num_st.phase = PH_FRAC;
    end else if (char_is_marker(c)) begin
      num_st.phase = PH_EXPMARK;
    end
  endfunction

  // Returns 1 when the character continues the number in progress.
  function automatic bit absorb_char(logic [7:0] c);
    case (num_st.phase)
      PH_INT: begin
        if (char_is_digit(c)) begin
          num_st.mant     = num_st.mant * 32'd10 + 32'(c - CH_ZERO);
          num_st.int_seen = 1'b1;
          return 1'b1;
        end
        if (c == CH_DOT) begin
          num_st.phase = PH_FRAC;
          return 1'b1;
        end
        if (char_is_marker(c)) begin
          num_st.phase = PH_EXPMARK;
          return 1'b1;
        end
        return 1'b0;
      end
      PH_FRAC: begin
        if (char_is_digit(c)) begin
          num_st.mant     = num_st.mant * 32'd10 + 32'(c - CH_ZERO);
          num_st.frac_cnt = num_st.frac_cnt + 16'd1;
          return 1'b1;
        end
        if (char_is_marker(c)) begin
          num_st.phase = PH_EXPMARK;
          return 1'b1;
        end
        return 1'b0;
      end
      PH_EXPMARK, PH_EXPSIGN, PH_EXPDIG: begin
        // The exponent sign is only allowed right after the marker.
        if (num_st.phase == PH_EXPMARK && c == CH_MINUS) begin
          num_st.exp_neg = 1'b1;
          num_st.phase   = PH_EXPSIGN;
          return 1'b1;
        end
        if (num_st.phase == PH_EXPMARK && c == CH_PLUS) begin
          num_st.phase = PH_EXPSIGN;
          return 1'b1;
        end
        if (char_is_digit(c)) begin
          num_st.exp_acc = num_st.exp_acc * 16'd10 + 16'(c - CH_ZERO);
          num_st.phase   = PH_EXPDIG;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Builds the result of the number in progress.
  function automatic snt_res_t finished_number();
    snt_res_t   r;
    logic [15:0] e;
    e = num_st.exp_neg ? 16'd0 - num_st.exp_acc : num_st.exp_acc;
    e = e - num_st.frac_cnt;
    r.valid_res = num_st.int_seen &&
                  !(num_st.phase == PH_EXPMARK || num_st.phase == PH_EXPSIGN);
    r.negative  = num_st.sign_neg;
    r.mantissa  = num_st.mant;
    r.exponent  = e;
    return r;
  endfunction

  // Advances the parser by one item; returns 1 when a number is finished.
  function automatic bit parse_item(logic kind, logic [7:0] c, output snt_res_t r);
    bit busy;
    busy = (num_st.phase >= PH_INT) && (num_st.phase <= PH_EXPDIG);
    r    = '0;
    if (!busy)
      num_st.phase = PH_IDLE;
    if (kind == KIND_FLUSH) begin
      if (!busy)
        return 1'b0;
      r = finished_number();
      clear_number();
      return 1'b1;
    end
    if (!busy) begin
      open_number(c);
      return 1'b0;
    end
    if (absorb_char(c))
      return 1'b0;
    r = finished_number();
    open_number(c);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one item per call, with an optional idle burst in front.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic kind, logic [7:0] c);
    snt_res_t r;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_char_code <= c;
    do @(posedge clk); while (in_stall);
    if (parse_item(kind, c, r))
      pending_numbers.push_back(r);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_item(KIND_CHAR, s[i]);
  endtask

  task automatic send_digits(int n);
    for (int i = 0; i < n; i++)
      send_item(KIND_CHAR, CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // One random number, mostly well formed, sometimes noise or truncated.
  task automatic send_random_number();
    logic [7:0] markers[4];
    int         pick;
    markers = '{CH_UPR_E, CH_LWR_E, CH_UPR_D, CH_LWR_D};
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // Noise byte or a stray flush.
      if ($urandom_range(0, 9) == 0)
        send_item(KIND_FLUSH, 8'($urandom_range(0, 255)));
      else
        send_item(KIND_CHAR, 8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 3))
      0: send_item(KIND_CHAR, CH_MINUS);
      1: send_item(KIND_CHAR, CH_PLUS);
      default: ;
    endcase
    // Integer part: rarely empty, sometimes long enough to wrap.
    pick = $urandom_range(0, 99);
    if (pick < 5)
      ;
    else if (pick < 15)
      send_digits($urandom_range(10, 14));
    else
      send_digits($urandom_range(1, 4));
    if ($urandom_range(0, 9) < 4) begin
      send_item(KIND_CHAR, CH_DOT);
      send_digits($urandom_range(0, 6));
    end
    if ($urandom_range(0, 9) < 4) begin
      send_item(KIND_CHAR, markers[2'($urandom_range(0, 3))]);
      case ($urandom_range(0, 3))
        0: send_item(KIND_CHAR, CH_MINUS);
        1: send_item(KIND_CHAR, CH_PLUS);
        default: ;
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0)
        ;
      else if (pick == 1)
        send_digits($urandom_range(5, 7));
      else
        send_digits($urandom_range(1, 3));
    end
    // Terminator: whitespace, any byte, a flush, or straight into the next number.
    case ($urandom_range(0, 5))
      0: send_item(KIND_CHAR, 8'h20);
      1: send_item(KIND_CHAR, 8'h09);
      2: send_item(KIND_CHAR, 8'h0A);
      3: send_item(KIND_CHAR, 8'($urandom_range(0, 255)));
      4: send_item(KIND_FLUSH, 8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    hold_req_q <= hold_req;
    if (hold_req && !hold_req_q) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (rx_burst > 0) begin
      out_stall <= 1'b1;
      rx_burst  <= rx_burst - 1;
    end else if (idle_enable && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      rx_burst  <= $urandom_range(1, 19) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest predicted number.
  always @(posedge clk) begin
    snt_res_t got;
    snt_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_valid_res, out_negative, out_mantissa, out_exponent};
      if (pending_numbers.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected item: valid_res=%0b negative=%0b mantissa=%0d exponent=%0d",
                   got.valid_res, got.negative, got.mantissa, $signed(got.exponent));
      end else begin
        want = pending_numbers.pop_front();
        if (got.valid_res !== want.valid_res || got.negative !== want.negative ||
            got.mantissa !== want.mantissa || got.exponent !== want.exponent) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch: expected %0b/%0b/%0d/%0d, got %0b/%0b/%0d/%0d",
                     want.valid_res, want.negative, want.mantissa, $signed(want.exponent),
                     got.valid_res, got.negative, got.mantissa, $signed(got.exponent));
        end
      end
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // A complete number with every part, ended by whitespace.
  task automatic test_number_forms();
    send_text("-1.5e+3 ");
  endtask

  // Numbers without integer digits, markers without digits, a lone marker.
  task automatic test_incomplete_forms();
    send_text(".5e-");
    send_item(KIND_FLUSH, 8'h00);
    send_text("+dE3");
    send_item(KIND_CHAR, 8'hFF);
    send_item(KIND_FLUSH, 8'hFF);
  endtask

  // Dropped characters in idle, a flush after a digit, a lone sign.
  task automatic test_drop_and_flush();
    send_item(KIND_CHAR, 8'h00);
    send_text("9");
    send_item(KIND_FLUSH, 8'hFF);
    send_text("--");
    send_item(KIND_FLUSH, 8'h00);
  endtask

  // Hold the output off while short numbers keep coming, so the input stalls.
  task automatic test_output_holdoff();
    hold_req <= 1'b1;
    for (int i = 0; i < 30; i++)
      send_text("7 ");
    hold_req <= 1'b0;
  endtask

  task automatic test_random_stream(int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at)
      send_random_number();
  endtask

  initial begin
    clear_number();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_number_forms();
    test_incomplete_forms();
    test_drop_and_flush();
    test_output_holdoff();
    test_random_stream(1500);
    idle_enable = 1'b0;
    test_random_stream(400);
    send_item(KIND_FLUSH, 8'h00);
    in_valid <= 1'b0;

    // Drain, then let the block settle before the final check.
    while (pending_numbers.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && pending_numbers.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
